FILE: rtl/acctr_pkg.sv
// Shared types and constants for the AC clutch torque reserve sequencer.
// No dependencies; imported by every module of the block.
`default_nettype none

package acctr_pkg;

    localparam int unsigned CNT_W = 11;
    localparam logic [CNT_W-1:0] COUNT_LIMIT = 11'd1500;

    localparam int unsigned ADDR_W = 4;
    localparam logic [1:0] REG_ENGAGE_TIMEOUT = 2'd0;
    localparam logic [1:0] REG_HOLD_TIME      = 2'd1;
    localparam logic [1:0] REG_INHIBIT        = 2'd2;

    typedef struct packed {
        logic [15:0] engage_timeout;
        logic [15:0] hold_time;
        logic        inhibit_on_clutch_open;
    } cfg_t;

    typedef struct packed {
        logic [CNT_W-1:0] hold_ticks;
        logic [CNT_W-1:0] engage_wait_ticks;
        logic             sequence_fault;
        logic             reserve_request;
        logic [2:0]       mode;
    } res_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        r = (v >= COUNT_LIMIT) ? COUNT_LIMIT : v + 1'b1;
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/acctr_cfg_regs.sv
// APB configuration registers: engage timeout, hold time, inhibit flag.
// Depends on acctr_pkg.
`default_nettype none

module acctr_cfg_regs
    import acctr_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.engage_timeout         <= 16'd1500;
            cfg_reg.hold_time              <= 16'd100;
            cfg_reg.inhibit_on_clutch_open <= 1'b0;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                REG_ENGAGE_TIMEOUT: cfg_reg.engage_timeout <= pwdata[15:0];
                REG_HOLD_TIME:      cfg_reg.hold_time <= pwdata[15:0];
                REG_INHIBIT:        cfg_reg.inhibit_on_clutch_open <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_ENGAGE_TIMEOUT: prdata = {16'd0, cfg_reg.engage_timeout};
            REG_HOLD_TIME:      prdata = {16'd0, cfg_reg.hold_time};
            REG_INHIBIT:        prdata = {31'd0, cfg_reg.inhibit_on_clutch_open};
            default:            prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/acctr_fsm.sv
// Sequencer state, flags and saturating tick counters; one update per request.
// Depends on acctr_pkg.
`default_nettype none

module acctr_fsm
    import acctr_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       step_en,
    input  wire logic       clutch_engaged,
    input  wire logic [7:0] ac_power,
    input  wire cfg_t       cfg,
    output res_t            res_next
);

    typedef enum logic [2:0] {
        ST_IDLE         = 3'd0,
        ST_WAIT_ENGAGE  = 3'd1,
        ST_FAULT        = 3'd2,
        ST_WAIT_RELEASE = 3'd3,
        ST_HOLD         = 3'd4
    } mode_t;

    mode_t            mode_reg, mode_next;
    logic             reserve_reg, reserve_next;
    logic             fault_reg, fault_next;
    logic [CNT_W-1:0] wait_reg, wait_next;
    logic [CNT_W-1:0] hold_reg, hold_next;
    logic             power_on;
    logic             open_release;

    assign power_on     = (ac_power != 8'd0);
    assign open_release = !clutch_engaged && (!power_on || cfg.inhibit_on_clutch_open);

    always_comb begin
        mode_next    = mode_reg;
        reserve_next = reserve_reg;
        fault_next   = fault_reg;
        wait_next    = wait_reg;
        hold_next    = hold_reg;
        unique case (mode_reg)
            ST_IDLE: begin
                if (clutch_engaged) begin
                    mode_next    = ST_FAULT;
                    reserve_next = 1'b0;
                    fault_next   = 1'b1;
                end else if (power_on) begin
                    mode_next    = ST_WAIT_ENGAGE;
                    reserve_next = 1'b1;
                    fault_next   = 1'b0;
                    wait_next    = '0;
                end
            end
            ST_WAIT_ENGAGE: begin
                if (!power_on) begin
                    mode_next    = ST_IDLE;
                    reserve_next = 1'b0;
                    fault_next   = 1'b0;
                end else if ({5'd0, wait_reg} >= cfg.engage_timeout) begin
                    mode_next    = ST_FAULT;
                    reserve_next = 1'b0;
                    fault_next   = 1'b1;
                end else if (clutch_engaged) begin
                    mode_next = ST_HOLD;
                    hold_next = '0;
                end else begin
                    wait_next = sat_inc(wait_reg);
                end
            end
            ST_FAULT: begin
                if (!power_on && !clutch_engaged) begin
                    mode_next    = ST_IDLE;
                    reserve_next = 1'b0;
                    fault_next   = 1'b0;
                end
            end
            ST_WAIT_RELEASE: begin
                if (open_release) begin
                    mode_next    = ST_IDLE;
                    reserve_next = 1'b0;
                    fault_next   = 1'b0;
                end
            end
            ST_HOLD: begin
                if (open_release) begin
                    mode_next    = ST_IDLE;
                    reserve_next = 1'b0;
                    fault_next   = 1'b0;
                end else if (({5'd0, hold_reg} >= cfg.hold_time) ||
                             (!clutch_engaged && !cfg.inhibit_on_clutch_open)) begin
                    mode_next    = ST_WAIT_RELEASE;
                    reserve_next = 1'b0;
                end else begin
                    hold_next = sat_inc(hold_reg);
                end
            end
            default: mode_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= ST_IDLE;
            reserve_reg <= 1'b0;
            fault_reg   <= 1'b0;
            wait_reg    <= '0;
            hold_reg    <= '0;
        end else if (step_en) begin
            mode_reg    <= mode_next;
            reserve_reg <= reserve_next;
            fault_reg   <= fault_next;
            wait_reg    <= wait_next;
            hold_reg    <= hold_next;
        end
    end

    assign res_next.mode              = mode_next;
    assign res_next.reserve_request   = reserve_next;
    assign res_next.sequence_fault    = fault_next;
    assign res_next.engage_wait_ticks = wait_next;
    assign res_next.hold_ticks        = hold_next;

    a_wait_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        wait_reg <= COUNT_LIMIT && hold_reg <= COUNT_LIMIT)
        else $error("tick counter above limit");

    a_fault_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        fault_reg |-> (mode_reg == ST_FAULT && !reserve_reg))
        else $error("fault flag outside fault mode");

    a_idle_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == ST_IDLE || mode_reg == ST_WAIT_RELEASE) |-> (!reserve_reg && !fault_reg))
        else $error("flags set in idle or wait release");

    a_hold_reserve: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == ST_HOLD || mode_reg == ST_WAIT_ENGAGE) |-> reserve_reg)
        else $error("reserve dropped while waiting or holding");

    a_no_step_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !step_en |=> $stable(mode_reg) && $stable(wait_reg) && $stable(hold_reg))
        else $error("state moved without a request");

endmodule

`default_nettype wire

FILE: rtl/ac_clutch_torque_reserve_fsm_unit.sv
// AC clutch torque reserve sequencer: top level with stream channels and APB port.
// Depends on acctr_pkg, acctr_cfg_regs and acctr_fsm.
//
// Each input request on the s_ channel is one tick: clutch state and AC power
// request. Each tick produces exactly one result on the m_ channel: the mode,
// reserve and fault flags and the two saturating tick counters after the tick.
// A request is registered in the input register on acceptance and is
// evaluated once the output register is empty or being read: the sequencer
// state then updates and the result is loaded into the output register,
// which drives m_tvalid.
// Throughput is one request per cycle while m_tready stays high; the
// state update loop in acctr_fsm sets that rate.
// When the receiver stalls, the result holds in the output register and one
// more request waits in the input register; s_tready then drops until the
// result is taken.
// Reset (aresetn low, synchronous) returns the sequencer to idle with flags
// and counters cleared, empties both registers, and restores the engage
// timeout to 1500, the hold time to 100 and the inhibit flag to 0.
// Registers: 0x0 engage_timeout, 0x4 hold_time, 0x8 inhibit_on_clutch_open;
// write them only while no request is in flight.
`default_nettype none

module ac_clutch_torque_reserve_fsm_unit
    import acctr_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [15:0]       s_tdata,  // clutch_engaged[0], ac_power[8:1]
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [31:0]            m_tdata,  // mode[2:0], reserve_request[3],
                                             // sequence_fault[4],
                                             // engage_wait_ticks[15:5],
                                             // hold_ticks[26:16]
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready
);

    cfg_t       cfg;
    res_t       res_next;
    logic       in_valid_reg;
    logic       in_clutch_reg;
    logic [7:0] in_power_reg;
    logic       out_valid_reg;
    res_t       out_reg;
    logic       advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    acctr_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    acctr_fsm u_fsm (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step_en        (advance),
        .clutch_engaged (in_clutch_reg),
        .ac_power       (in_power_reg),
        .cfg            (cfg),
        .res_next       (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_clutch_reg <= s_tdata[0];
            in_power_reg  <= s_tdata[8:1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_reg};

endmodule

`default_nettype wire

FILE: dv/tb_ac_clutch_torque_reserve_fsm_unit.sv
// Testbench for ac_clutch_torque_reserve_fsm_unit: drives clutch/power ticks on the
// s_ stream, checks every m_ result against a local sequencer model, writes registers
// over APB between phases. Depends on acctr_pkg and the RTL of the block only.
`default_nettype none

module tb_ac_clutch_torque_reserve_fsm_unit
    import acctr_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT  = 600000;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam logic [1:0]  REG_UNUSED   = 2'd3;

    typedef enum logic [2:0] {
        MODE_IDLE         = 3'd0,
        MODE_WAIT_ENGAGE  = 3'd1,
        MODE_FAULT        = 3'd2,
        MODE_WAIT_RELEASE = 3'd3,
        MODE_HOLD         = 3'd4
    } seq_mode_e;

    typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_SPARSE} rx_style_e;

    typedef struct packed {
        logic       clutch;
        logic [7:0] power;
    } tick_t;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [15:0]       s_tdata  = '0;   // clutch_engaged[0], ac_power[8:1]
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [31:0]       m_tdata;         // mode[2:0], reserve_request[3], sequence_fault[4],
                                        // engage_wait_ticks[15:5], hold_ticks[26:16]
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [ADDR_W-1:0] paddr    = '0;
    logic [31:0]       pwdata   = '0;
    logic [31:0]       prdata;
    logic              pready;

    ac_clutch_torque_reserve_fsm_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 aclk = ~aclk;

    // sequencer model state and its register copy
    logic [15:0]      cfg_timeout = 16'd1500;
    logic [15:0]      cfg_hold    = 16'd100;
    logic             cfg_inhibit = 1'b0;
    seq_mode_e        seq_mode    = MODE_IDLE;
    logic             seq_reserve = 1'b0;
    logic             seq_fault   = 1'b0;
    logic [CNT_W-1:0] seq_wait    = '0;
    logic [CNT_W-1:0] seq_hold    = '0;

    tick_t       tick_q[$];
    res_t        result_q[$];
    int unsigned pushed_cnt   = 0;
    int unsigned accepted_cnt = 0;
    int unsigned err_cnt      = 0;
    int unsigned cycle_cnt    = 0;
    logic        s_took       = 1'b0;

    int          tx_gap_max    = 0;
    int          tx_gap_left   = 0;
    int          tx_burst_left = 0;
    rx_style_e   rx_style      = RX_ALWAYS;
    int unsigned rx_phase      = 0;
    int          holdoff_left  = 0;
    logic        holdoff_req   = 1'b0;

    function automatic void drop_to_idle();
        seq_mode    = MODE_IDLE;
        seq_reserve = 1'b0;
        seq_fault   = 1'b0;
    endfunction

    function automatic void raise_fault();
        seq_mode    = MODE_FAULT;
        seq_reserve = 1'b0;
        seq_fault   = 1'b1;
    endfunction

    function automatic res_t advance_sequencer(input logic clutch, input logic [7:0] power);
        logic released;
        res_t r;
        released = !clutch && (power == 8'd0 || cfg_inhibit);
        case (seq_mode)
            MODE_IDLE: begin
                if (clutch) begin
                    raise_fault();
                end else if (power != 8'd0) begin
                    seq_mode    = MODE_WAIT_ENGAGE;
                    seq_reserve = 1'b1;
                    seq_fault   = 1'b0;
                    seq_wait    = '0;
                end
            end
            MODE_WAIT_ENGAGE: begin
                if (power == 8'd0) begin
                    drop_to_idle();
                end else if ({5'd0, seq_wait} >= cfg_timeout) begin
                    raise_fault();
                end else if (clutch) begin
                    seq_mode = MODE_HOLD;
                    seq_hold = '0;
                end else if (seq_wait != COUNT_LIMIT) begin
                    seq_wait = seq_wait + 1'b1;
                end
            end
            MODE_FAULT: begin
                if (power == 8'd0 && !clutch) drop_to_idle();
            end
            MODE_WAIT_RELEASE: begin
                if (released) drop_to_idle();
            end
            MODE_HOLD: begin
                if (released) begin
                    drop_to_idle();
                end else if ({5'd0, seq_hold} >= cfg_hold || (!clutch && !cfg_inhibit)) begin
                    seq_mode    = MODE_WAIT_RELEASE;
                    seq_reserve = 1'b0;
                end else if (seq_hold != COUNT_LIMIT) begin
                    seq_hold = seq_hold + 1'b1;
                end
            end
            default: seq_mode = MODE_IDLE;
        endcase
        r.mode              = seq_mode;
        r.reserve_request   = seq_reserve;
        r.sequence_fault    = seq_fault;
        r.engage_wait_ticks = seq_wait;
        r.hold_ticks        = seq_hold;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch %s: got %0d expected %0d", $realtime, field, got, want);
        err_cnt++;
    endtask

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        res_t want;
        res_t got;
        s_took = aresetn && s_tvalid && s_tready;
        if (s_took) begin
            result_q.push_back(advance_sequencer(s_tdata[0], s_tdata[8:1]));
            accepted_cnt++;
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (result_q.size() == 0) begin
                report_mismatch("unexpected result", m_tdata, 32'd0);
            end else begin
                want = result_q.pop_front();
                got  = m_tdata[26:0];
                if (got.mode != want.mode)
                    report_mismatch("mode", 32'(got.mode), 32'(want.mode));
                if (got.reserve_request != want.reserve_request)
                    report_mismatch("reserve_request", 32'(got.reserve_request),
                                    32'(want.reserve_request));
                if (got.sequence_fault != want.sequence_fault)
                    report_mismatch("sequence_fault", 32'(got.sequence_fault),
                                    32'(want.sequence_fault));
                if (got.engage_wait_ticks != want.engage_wait_ticks)
                    report_mismatch("engage_wait_ticks", 32'(got.engage_wait_ticks),
                                    32'(want.engage_wait_ticks));
                if (got.hold_ticks != want.hold_ticks)
                    report_mismatch("hold_ticks", 32'(got.hold_ticks), 32'(want.hold_ticks));
                if (m_tdata[31:27] != 5'd0)
                    report_mismatch("tdata padding", 32'(m_tdata[31:27]), 32'd0);
            end
        end
    end

    // request driver: hold an offered request until taken, then advance in bursts
    always @(negedge aclk) begin
        tick_t nxt;
        if (!(s_tvalid && !s_took)) begin
            if (tx_gap_left > 0) begin
                tx_gap_left--;
                s_tvalid <= 1'b0;
            end else if (tick_q.size() > 0) begin
                nxt = tick_q.pop_front();
                s_tdata  <= {7'd0, nxt.power, nxt.clutch};
                s_tvalid <= 1'b1;
                if (tx_burst_left > 0) begin
                    tx_burst_left--;
                end else begin
                    tx_burst_left = $urandom_range(0, 24);
                    tx_gap_left   = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (holdoff_req) begin
            holdoff_left = 300;
            holdoff_req  = 1'b0;
        end
        if (holdoff_left > 0) begin
            holdoff_left--;
            m_tready <= 1'b0;
        end else begin
            case (rx_style)
                RX_ALWAYS:  m_tready <= 1'b1;
                RX_RANDOM:  m_tready <= ($urandom_range(0, 3) != 0);
                RX_PATTERN: m_tready <= ((rx_phase % 7) < 3);
                default:    m_tready <= ($urandom_range(0, 4) == 0);
            endcase
        end
        rx_phase++;
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        case (idx)
            REG_ENGAGE_TIMEOUT: cfg_timeout = value[15:0];
            REG_HOLD_TIME:      cfg_hold    = value[15:0];
            REG_INHIBIT:        cfg_inhibit = value[0];
            default: ;
        endcase
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic push_tick(input logic clutch, input logic [7:0] power);
        tick_q.push_back('{clutch: clutch, power: power});
        pushed_cnt++;
    endtask

    function automatic logic [7:0] pick_power();
        case ($urandom_range(0, 9))
            0:       return 8'd1;
            1:       return 8'd255;
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    task automatic push_run(input logic clutch, input int count);
        repeat (count) push_tick(clutch, pick_power());
    endtask

    task automatic add_episode(input int max_wait, input int max_hold);
        int kind;
        kind = $urandom_range(0, 9);
        if (kind < 6) begin
            repeat ($urandom_range(0, 2)) push_tick(1'b0, 8'd0);
            push_run(1'b0, $urandom_range(1, max_wait + 1));
            repeat ($urandom_range(1, max_hold + 1))
                push_tick(1'b1, ($urandom_range(0, 3) == 0) ? 8'd0 : pick_power());
            if ($urandom_range(0, 1)) push_run(1'b0, $urandom_range(1, 3));
            if ($urandom_range(0, 2) == 0) push_tick(1'b1, 8'($urandom_range(0, 255)));
            repeat ($urandom_range(1, 2)) push_tick(1'b0, 8'd0);
        end else if (kind < 8) begin
            repeat ($urandom_range(1, 4))
                push_tick(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            push_tick(1'b1, 8'($urandom_range(0, 255)));
            push_tick(1'b0, pick_power());
            push_tick(1'b0, 8'd0);
        end else begin
            repeat ($urandom_range(1, 8))
                push_tick(1'($urandom_range(0, 1)),
                          ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic add_random(input int count, input int max_wait, input int max_hold);
        int unsigned start;
        start = pushed_cnt;
        while (pushed_cnt - start < count) add_episode(max_wait, max_hold);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        while (accepted_cnt != pushed_cnt || result_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        repeat (2) @(negedge aclk);

        // reset settings, directed walk through every mode and the non-timeout exits
        push_tick(1'b0, 8'd0);
        push_tick(1'b1, 8'd0);
        push_tick(1'b1, 8'd255);
        push_tick(1'b0, 8'd255);
        push_tick(1'b0, 8'd0);
        push_tick(1'b0, 8'd1);
        push_tick(1'b0, 8'd255);
        push_tick(1'b0, 8'd0);
        push_tick(1'b0, 8'd128);
        push_tick(1'b1, 8'd128);
        push_tick(1'b1, 8'd255);
        push_tick(1'b0, 8'd77);
        push_tick(1'b1, 8'd5);
        push_tick(1'b0, 8'd9);
        push_tick(1'b0, 8'd0);
        push_tick(1'b0, 8'd200);
        push_tick(1'b1, 8'd200);
        push_tick(1'b1, 8'd0);
        push_tick(1'b0, 8'd0);
        push_tick(1'b1, 8'd1);
        push_tick(1'b0, 8'd1);
        push_tick(1'b0, 8'd0);
        wait_drained();

        write_reg(REG_ENGAGE_TIMEOUT, 32'h5A5A_0003);
        write_reg(REG_HOLD_TIME, 32'hA5A5_0002);
        write_reg(REG_INHIBIT, 32'h0000_0000);
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        tx_gap_max = 6;
        rx_style   = RX_RANDOM;
        add_random(160, 6, 5);
        wait_drained();

        // zero timeouts, inhibit set; stall the receiver while requests keep coming
        write_reg(REG_ENGAGE_TIMEOUT, 32'd0);
        write_reg(REG_HOLD_TIME, 32'd0);
        write_reg(REG_INHIBIT, 32'h0000_0003);
        tx_gap_max  = 3;
        rx_style    = RX_PATTERN;
        holdoff_req = 1'b1;
        add_random(160, 3, 3);
        wait_drained();

        // timeouts above the counter limit: long waits and holds never time out
        write_reg(REG_ENGAGE_TIMEOUT, 32'h0000_FFFF);
        write_reg(REG_HOLD_TIME, 32'h0000_FFFF);
        write_reg(REG_INHIBIT, 32'd0);
        tx_gap_max = 0;
        rx_style   = RX_ALWAYS;
        push_tick(1'b0, 8'd0);
        push_run(1'b0, 60);
        push_run(1'b1, 60);
        push_tick(1'b0, 8'd0);
        add_random(60, 4, 4);
        wait_drained();

        // large timeouts with inhibit set
        write_reg(REG_ENGAGE_TIMEOUT, 32'd1500);
        write_reg(REG_HOLD_TIME, 32'd1500);
        write_reg(REG_INHIBIT, 32'd1);
        tx_gap_max = 2;
        rx_style   = RX_SPARSE;
        push_tick(1'b0, 8'd0);
        push_run(1'b0, 60);
        push_tick(1'b0, 8'd0);
        push_run(1'b0, 2);
        push_run(1'b1, 60);
        push_tick(1'b0, 8'd0);
        add_random(40, 4, 4);
        wait_drained();

        write_reg(REG_ENGAGE_TIMEOUT, 32'd10);
        write_reg(REG_HOLD_TIME, 32'd8);
        write_reg(REG_INHIBIT, 32'd1);
        tx_gap_max = 8;
        rx_style   = RX_RANDOM;
        add_random(150, 14, 12);
        wait_drained();

        write_reg(REG_ENGAGE_TIMEOUT, $urandom_range(1, 20));
        write_reg(REG_HOLD_TIME, $urandom_range(0, 20));
        write_reg(REG_INHIBIT, $urandom_range(0, 1));
        tx_gap_max = 4;
        rx_style   = RX_PATTERN;
        add_random(120, 25, 25);
        wait_drained();

        if (err_cnt == 0 && result_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/acctr_pkg.sv
rtl/acctr_cfg_regs.sv
rtl/acctr_fsm.sv
rtl/ac_clutch_torque_reserve_fsm_unit.sv
dv/tb_ac_clutch_torque_reserve_fsm_unit.sv
